/* rtl/u8u16_pkg.sv */
// Package: shared types, constants and the code point to UTF-16 mapping.
`default_nettype none

package u8u16_pkg;

	// Lead byte boundaries
	localparam logic [7:0] LEAD2_MIN = 8'hC0;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;

	// Continuation bytes carry six payload bits
	localparam int unsigned CONT_BITS = 6;
	localparam int unsigned CP_W      = 21;

	localparam logic [CP_W-1:0] BMP_MAX    = 21'h00FFFF;
	localparam logic [CP_W-1:0] MAX_CP     = 21'h10FFFF;
	localparam logic [CP_W-1:0] PLANE1_BASE = 21'h010000;

	localparam logic [15:0] SUR_HIGH    = 16'hD800;
	localparam logic [15:0] SUR_LOW     = 16'hDC00;
	localparam logic [15:0] REPLACEMENT = 16'hFFFD;

	// One result unit
	typedef struct packed {
		logic [15:0] unit;
		logic        last_of_run;
		logic        out_of_range;
	} unit_item_t;

	// Results of one finished code point
	typedef struct packed {
		logic       pair;
		unit_item_t first;
		unit_item_t second;
	} emit_t;

	// Map a code point to one unit, a surrogate pair or the replacement unit
	function automatic emit_t emit_cp(input logic [CP_W-1:0] cp);
		emit_t           e;
		logic [CP_W-1:0] v;
		v = cp - PLANE1_BASE;
		e.pair                = 1'b0;
		e.first.unit          = cp[15:0];
		e.first.last_of_run   = 1'b1;
		e.first.out_of_range  = 1'b0;
		e.second.unit         = SUR_LOW | {6'b0, v[9:0]};
		e.second.last_of_run  = 1'b1;
		e.second.out_of_range = 1'b0;
		if (cp > MAX_CP) begin
			e.first.unit         = REPLACEMENT;
			e.first.out_of_range = 1'b1;
		end else if (cp > BMP_MAX) begin
			e.pair              = 1'b1;
			e.first.unit        = SUR_HIGH | {6'b0, v[19:10]};
			e.first.last_of_run = 1'b0;
		end
		return e;
	endfunction

endpackage

`default_nettype wire

/* rtl/u8u16_in_if.sv */
// Interface: UTF-8 byte channel.
`default_nettype none

interface u8u16_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_string;

	modport source (output valid, output data_byte, output end_of_string, input ready);
	modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

/* rtl/u8u16_out_if.sv */
// Interface: UTF-16 code unit channel.
`default_nettype none

interface u8u16_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] unit;
	logic        last_of_run;
	logic        out_of_range;

	modport source (output valid, output unit, output last_of_run, output out_of_range,
		input ready);
	modport sink   (input valid, input unit, input last_of_run, input out_of_range,
		output ready);
endinterface

`default_nettype wire

/* rtl/utf8_to_utf16_transcoder.sv */
// Top level: UTF-8 byte stream to UTF-16 code unit stream.
`default_nettype none

// Accepts one UTF-8 byte per cycle on utf8 and delivers UTF-16 units on utf16.
// A byte is registered, decoded against the open sequence in the next cycle,
// and a finished code point is loaded into the result register once its
// units fit there, so its first unit is offered from that register and
// leaves when utf16 is ready. The result side holds two units, the shown
// one and one queued behind it: a code point from 0x10000 to 0x10FFFF gives
// a surrogate pair (high unit first, last_of_run low on it), and a
// single unit may queue behind a waiting low surrogate. A steady byte stream
// is therefore taken at one byte per cycle while utf16 keeps up; the input
// stalls only when the units of a finished code point do not fit in the
// slots left free after this cycle's transfer. Code points above 0x10FFFF
// come out as 0xFFFD with out_of_range set. end_of_string on a byte that
// leaves a sequence unfinished drops that sequence silently. Continuation
// bytes are not checked; only their low six bits are used.
module utf8_to_utf16_transcoder
	import u8u16_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	u8u16_in_if.sink     utf8,
	u8u16_out_if.source  utf16
);

	// Input register
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            eos_s1;

	// Decoder state
	logic [CP_W-1:0] partial_q;
	logic [1:0]      remain_q;

	// Result register and the unit queued behind it
	logic            out_vld_q;
	unit_item_t      out_q;
	logic            pend_vld_q;
	unit_item_t      pend_q;

	logic            emit_req;
	logic [CP_W-1:0] cp_c;
	logic [CP_W-1:0] partial_d;
	logic [1:0]      remain_d;
	logic [CP_W-1:0] shifted;
	emit_t           emit_c;
	logic            out_xfer;
	logic            head_free;
	logic            load_ok;
	logic            adv;

	// Decode the registered byte against the open sequence
	assign shifted = {partial_q[CP_W-1-CONT_BITS:0], byte_s1[CONT_BITS-1:0]};

	always_comb begin
		emit_req  = 1'b0;
		cp_c      = {13'b0, byte_s1};
		partial_d = partial_q;
		remain_d  = remain_q;
		if (remain_q == 2'd0) begin
			if (byte_s1 < LEAD2_MIN) begin
				emit_req  = 1'b1;
				partial_d = '0;
			end else if (byte_s1 < LEAD3_MIN) begin
				partial_d = {16'b0, byte_s1[4:0]};
				remain_d  = 2'd1;
			end else if (byte_s1 < LEAD4_MIN) begin
				partial_d = {17'b0, byte_s1[3:0]};
				remain_d  = 2'd2;
			end else begin
				partial_d = {18'b0, byte_s1[2:0]};
				remain_d  = 2'd3;
			end
		end else begin
			remain_d = remain_q - 2'd1;
			if (remain_d == 2'd0) begin
				emit_req  = 1'b1;
				cp_c      = shifted;
				partial_d = '0;
			end else begin
				partial_d = shifted;
			end
		end
		// Drop an unfinished sequence at the end of the string
		if (!emit_req && eos_s1) begin
			partial_d = '0;
			remain_d  = 2'd0;
		end
	end

	assign emit_c = emit_cp(cp_c);

	// Handshake: take a code point when its units fit after this cycle's transfer
	assign out_xfer   = out_vld_q && utf16.ready;
	assign head_free  = !out_vld_q || (out_xfer && !pend_vld_q);
	assign load_ok    = head_free || (!emit_c.pair && (!pend_vld_q || out_xfer));
	assign adv        = valid_s1 && (!emit_req || load_ok);
	assign utf8.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (utf8.ready) begin
			valid_s1 <= utf8.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (utf8.ready && utf8.valid) begin
			byte_s1 <= utf8.data_byte;
			eos_s1  <= utf8.end_of_string;
		end
	end

	// Advance the decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			remain_q  <= 2'd0;
		end else if (adv) begin
			partial_q <= partial_d;
			remain_q  <= remain_d;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else if (adv && emit_req) begin
			out_vld_q  <= 1'b1;
			pend_vld_q <= head_free ? emit_c.pair : 1'b1;
		end else if (out_xfer) begin
			out_vld_q  <= pend_vld_q;
			pend_vld_q <= 1'b0;
		end
	end

	// Result payload: load a new code point, queue it behind, or shift up
	always_ff @(posedge clk) begin
		if (adv && emit_req) begin
			if (head_free) begin
				out_q  <= emit_c.first;
				pend_q <= emit_c.second;
			end else begin
				pend_q <= emit_c.first;
				if (out_xfer) begin
					out_q <= pend_q;
				end
			end
		end else if (out_xfer && pend_vld_q) begin
			out_q <= pend_q;
		end
	end

	assign utf16.valid        = out_vld_q;
	assign utf16.unit         = out_q.unit;
	assign utf16.last_of_run  = out_q.last_of_run;
	assign utf16.out_of_range = out_q.out_of_range;

`ifndef SYNTH
	// A queued unit always sits behind a shown unit
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> out_vld_q)
		else $error("pending unit without a shown unit");

	// A shown high surrogate always has its low half waiting
	a_high_has_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_q.last_of_run) |-> pend_vld_q)
		else $error("high surrogate without its low half");

	// No sequence stays open after the last byte of a string
	a_eos_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && eos_s1) |=> (remain_q == 2'd0))
		else $error("sequence still open after end of string");

	// Gathered bits are cleared whenever no sequence is open
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(remain_q == 2'd0) |-> (partial_q == '0))
		else $error("partial code point left over");
`endif

endmodule

`default_nettype wire
